// File: hdl/mte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, character codes and base-letter helpers for the MD tag
// mismatch extractor.
// ----------------------------------------------------------------------------
package mte_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BASE    = 2'd1,
    CMD_MD_CHAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_MISMATCH = 2'd0,
    KIND_INVALID  = 2'd1,
    KIND_BEYOND   = 2'd2
  } kind_t;

  localparam logic [7:0]  CH_A    = 8'h41;
  localparam logic [7:0]  CH_C    = 8'h43;
  localparam logic [7:0]  CH_G    = 8'h47;
  localparam logic [7:0]  CH_N    = 8'h4E;
  localparam logic [7:0]  CH_T    = 8'h54;
  localparam logic [7:0]  CH_ZERO = 8'h30;
  localparam logic [7:0]  CH_NINE = 8'h39;
  localparam logic [7:0]  CH_UA   = 8'h41;
  localparam logic [7:0]  CH_UZ   = 8'h5A;
  localparam logic [7:0]  CH_LA   = 8'h61;
  localparam logic [7:0]  CH_LZ   = 8'h7A;
  localparam logic [7:0]  CASE_OFFSET = 8'd32;
  localparam logic [3:0]  CODE_NONE = 4'h0;
  localparam logic [3:0]  CODE_N    = 4'hF;
  localparam logic [10:0] RUN_MAX   = 11'h7FF;

  // Request handed from the parse stage to the emit stage.
  typedef struct packed {
    kind_t       kind;
    logic [10:0] position;
    logic [7:0]  ref_base;
    logic [7:0]  obs_base;
    logic        use_ram;
    logic        reverse;
  } req_t;

  function automatic logic [7:0] code_to_letter(input logic [3:0] code);
    logic [7:0] letter;
    if (code == CODE_N || code == CODE_NONE) begin
      letter = CH_N;
    end else if (code[0]) begin
      letter = CH_A;
    end else if (code[1]) begin
      letter = CH_C;
    end else if (code[2]) begin
      letter = CH_G;
    end else begin
      letter = CH_T;
    end
    return letter;
  endfunction

  function automatic logic [7:0] complement_letter(input logic [7:0] c);
    logic [7:0] up;
    logic [7:0] res;
    up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFFSET : c;
    case (up)
      CH_A:    res = CH_T;
      CH_T:    res = CH_A;
      CH_C:    res = CH_G;
      CH_G:    res = CH_C;
      default: res = CH_N;
    endcase
    return res;
  endfunction

endpackage

// File: hdl/mte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mte_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/mte_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_parse
// Parse state (run, cursor, length, strand) and decode of one request per
// cycle when accept is high; issues base writes and the base read for mismatches.
// ----------------------------------------------------------------------------
module mte_parse import mte_pkg::*; #(
  parameter int MAX_READ_LEN = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [1:0]                      command,
  input  logic [10:0]                     read_length,
  input  logic                            is_reverse,
  input  logic [9:0]                      base_index,
  input  logic [3:0]                      base_code,
  input  logic [7:0]                      md_char,
  output logic                            req_valid,
  output req_t                            req,
  output logic                            ram_we,
  output logic [$clog2(MAX_READ_LEN)-1:0] ram_waddr,
  output logic [3:0]                      ram_wdata,
  output logic [$clog2(MAX_READ_LEN)-1:0] ram_raddr
);

  localparam int AW = $clog2(MAX_READ_LEN);

  logic [10:0] run_r, run_nxt;
  logic [10:0] cursor_r, cursor_nxt;
  logic [10:0] len_r, len_nxt;
  logic        rev_r, rev_nxt;

  logic [11:0] pos;
  logic        beyond;
  logic [14:0] run_sum;
  logic        is_digit;
  logic        is_letter;
  logic [7:0]  ref_letter;
  logic        base_ok;

  assign pos        = {1'b0, cursor_r} + {1'b0, run_r};
  assign beyond     = pos >= {1'b0, len_r};
  assign run_sum    = 15'(run_r) * 15'd10 + 15'(4'(md_char - CH_ZERO));
  assign ref_letter = rev_r ? complement_letter(md_char) : md_char;
  assign base_ok    = 32'(base_index) < 32'(MAX_READ_LEN);
  assign ram_waddr  = AW'(base_index);
  assign ram_wdata  = base_code;
  assign ram_raddr  = AW'(pos);

  always_comb begin
    is_digit  = md_char inside {[CH_ZERO:CH_NINE]};
    is_letter = md_char inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
    run_nxt    = run_r;
    cursor_nxt = cursor_r;
    len_nxt    = len_r;
    rev_nxt    = rev_r;
    ram_we     = 1'b0;
    req_valid  = 1'b0;
    req.kind     = KIND_MISMATCH;
    req.position = '0;
    req.ref_base = ref_letter;
    req.obs_base = CH_N;
    req.use_ram  = 1'b0;
    req.reverse  = rev_r;
    case (command)
      CMD_START: begin
        len_nxt    = (32'(read_length) > 32'(MAX_READ_LEN)) ? 11'(MAX_READ_LEN)
                                                            : read_length;
        rev_nxt    = is_reverse;
        run_nxt    = '0;
        cursor_nxt = '0;
      end
      CMD_BASE: begin
        ram_we = accept && base_ok;
      end
      CMD_MD_CHAR: begin
        if (is_digit) begin
          run_nxt = (run_sum > 15'(RUN_MAX)) ? RUN_MAX : run_sum[10:0];
        end else if (is_letter) begin
          req_valid = 1'b1;
          run_nxt   = '0;
          if (beyond) begin
            // Saturate at the end of the read.
            cursor_nxt   = len_r;
            req.kind     = KIND_BEYOND;
            req.position = len_r;
          end else begin
            cursor_nxt   = pos[10:0] + 11'd1;
            req.kind     = KIND_MISMATCH;
            req.use_ram  = 1'b1;
            req.position = rev_r ? len_r - pos[10:0] : pos[10:0] + 11'd1;
          end
        end else begin
          req_valid    = 1'b1;
          req.kind     = KIND_INVALID;
          req.ref_base = md_char;
          req.obs_base = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= '0;
      cursor_r <= '0;
      len_r    <= '0;
      rev_r    <= 1'b0;
    end else if (accept) begin
      run_r    <= run_nxt;
      cursor_r <= cursor_nxt;
      len_r    <= len_nxt;
      rev_r    <= rev_nxt;
    end
  end

endmodule

// File: hdl/mte_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_emit
// Holds a request while its base read completes, resolves the observed base
// and drives the result register.
// ----------------------------------------------------------------------------
module mte_emit import mte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        req_valid,
  input  req_t        req,
  input  logic [3:0]  ram_rdata,
  output logic        can_accept,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [10:0] out_position,
  output logic [7:0]  out_reference_base,
  output logic [7:0]  out_observed_base
);

  logic        hold_valid_r;
  req_t        hold_r;
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [10:0] position_r;
  logic [7:0]  ref_r;
  logic [7:0]  obs_r;

  logic        out_free;
  logic [7:0]  base_letter;
  logic [7:0]  obs_nxt;

  assign out_free   = !out_valid_r || !out_stall;
  assign can_accept = !hold_valid_r || out_free;

  assign base_letter = code_to_letter(ram_rdata);
  assign obs_nxt     = !hold_r.use_ram ? hold_r.obs_base :
                       hold_r.reverse  ? complement_letter(base_letter) : base_letter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (can_accept) begin
        hold_valid_r <= accept && req_valid;
      end
      if (out_free) begin
        out_valid_r <= hold_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_accept && accept) begin
      hold_r <= req;
    end
    if (out_free && hold_valid_r) begin
      kind_r     <= hold_r.kind;
      position_r <= hold_r.position;
      ref_r      <= hold_r.ref_base;
      obs_r      <= obs_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_position       = position_r;
  assign out_reference_base = ref_r;
  assign out_observed_base  = obs_r;

endmodule

// File: hdl/md_tag_mismatch_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md_tag_mismatch_extractor
// Walks an MD tag one character per request against a stored read and
// reports mismatches, invalid characters and positions beyond the read.
// ----------------------------------------------------------------------------
// The block takes one request every cycle while in_stall is low (start, base
// write or MD tag character). A letter or an invalid character that is taken
// goes to the holding stage and then, when the output is not stalled, to the
// result register. The read base store has MAX_READ_LEN entries of 4 bits
// with one write port and one registered read port; the read is issued in the
// cycle the letter is taken. The store is not cleared after reset; a base must
// be written before a letter refers to it. A result waiting under stall does
// not stop new requests until the holding stage also fills.
module md_tag_mismatch_extractor import mte_pkg::*; #(
  parameter int MAX_READ_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_read_length,
  input  logic        in_is_reverse,
  input  logic [9:0]  in_base_index,
  input  logic [3:0]  in_base_code,
  input  logic [7:0]  in_md_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [10:0] out_position,
  output logic [7:0]  out_reference_base,
  output logic [7:0]  out_observed_base
);

  localparam int AW = $clog2(MAX_READ_LEN);

  logic          accept;
  logic          can_accept;
  logic          req_valid;
  req_t          req;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [3:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [3:0]    ram_rdata;

  assign in_stall = !can_accept;
  assign accept   = in_valid && can_accept;

  mte_parse #(
    .MAX_READ_LEN(MAX_READ_LEN)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .read_length(in_read_length),
    .is_reverse (in_is_reverse),
    .base_index (in_base_index),
    .base_code  (in_base_code),
    .md_char    (in_md_char),
    .req_valid  (req_valid),
    .req        (req),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr)
  );

  mte_ram #(
    .WIDTH(4),
    .DEPTH(MAX_READ_LEN)
  ) u_bases (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mte_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .req_valid         (req_valid),
    .req               (req),
    .ram_rdata         (ram_rdata),
    .can_accept        (can_accept),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_position      (out_position),
    .out_reference_base(out_reference_base),
    .out_observed_base (out_observed_base)
  );

endmodule

// File: bench/md_tag_mismatch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md_tag_mismatch_checker
// Watches both channels of the MD tag mismatch extractor. It keeps its own
// copy of the read store and the parse state, predicts the report for every
// accepted letter or invalid MD character and compares each accepted report
// with the oldest prediction.
// ----------------------------------------------------------------------------
module md_tag_mismatch_checker import mte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_read_length,
  input  logic        in_is_reverse,
  input  logic [9:0]  in_base_index,
  input  logic [3:0]  in_base_code,
  input  logic [7:0]  in_md_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [10:0] out_position,
  input  logic [7:0]  out_reference_base,
  input  logic [7:0]  out_observed_base,
  output int          mismatch_count,
  output int          outstanding
);

  localparam int READ_CAP = 1024;
  localparam int RUN_CAP  = 2047;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] position;
    logic [7:0]  ref_base;
    logic [7:0]  obs_base;
  } report_t;

  report_t    expected_reports[$];
  logic [3:0] read_store[READ_CAP];
  int         run_len;
  int         cursor_pos;
  int         read_len;
  logic       rev_strand;
  int         err_total = 0;

  // Append a prediction at the tail of the pending list.
  function automatic void queue_report(input report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic logic [7:0] code_letter(input logic [3:0] code);
    casez (code)
      4'b0000, 4'b1111: return CH_N;
      4'b???1:          return CH_A;
      4'b??10:          return CH_C;
      4'b?100:          return CH_G;
      default:          return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] opposite_base(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= CH_LA && ch <= CH_LZ) ? ch - CASE_OFFSET : ch;
    case (up)
      CH_A:    return CH_T;
      CH_T:    return CH_A;
      CH_C:    return CH_G;
      CH_G:    return CH_C;
      default: return CH_N;
    endcase
  endfunction

  always @(posedge clk) begin : track
    report_t    got;
    report_t    want;
    int         where;
    logic [7:0] ref_ch;
    logic [7:0] obs_ch;
    if (!rst_n) begin
      expected_reports.delete();
      run_len    = 0;
      cursor_pos = 0;
      read_len   = 0;
      rev_strand = 1'b0;
    end else begin
      // Compare first: a report never belongs to the request taken at this edge.
      if (out_valid && !out_stall) begin
        got = '{kind_t'(out_kind), out_position, out_reference_base, out_observed_base};
        if (expected_reports.size() == 0) begin
          $error("report with nothing pending: kind %0d position %0d ref %h obs %h",
                 out_kind, out_position, out_reference_base, out_observed_base);
          err_total++;
        end else begin
          want = expected_reports.pop_front();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            err_total++;
          end
          if (got.position != want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            err_total++;
          end
          if (got.ref_base != want.ref_base) begin
            $error("reference_base: expected %h, actual %h", want.ref_base, got.ref_base);
            err_total++;
          end
          if (got.obs_base != want.obs_base) begin
            $error("observed_base: expected %h, actual %h", want.obs_base, got.obs_base);
            err_total++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_command)
          CMD_START: begin
            read_len   = (in_read_length > READ_CAP) ? READ_CAP : in_read_length;
            rev_strand = in_is_reverse;
            run_len    = 0;
            cursor_pos = 0;
          end
          CMD_BASE: begin
            read_store[in_base_index] = in_base_code;
          end
          CMD_MD_CHAR: begin
            if (in_md_char >= CH_ZERO && in_md_char <= CH_NINE) begin
              run_len = run_len * 10 + int'(in_md_char - CH_ZERO);
              if (run_len > RUN_CAP) run_len = RUN_CAP;
            end else if (!((in_md_char >= CH_UA && in_md_char <= CH_UZ) ||
                           (in_md_char >= CH_LA && in_md_char <= CH_LZ))) begin
              // Not part of an MD tag: report it, parse state untouched.
              queue_report('{KIND_INVALID, 11'd0, in_md_char, 8'd0});
            end else begin
              where  = cursor_pos + run_len;
              ref_ch = rev_strand ? opposite_base(in_md_char) : in_md_char;
              run_len = 0;
              if (where >= read_len) begin
                cursor_pos = read_len;
                queue_report('{KIND_BEYOND, 11'(read_len), ref_ch, CH_N});
              end else begin
                obs_ch = code_letter(read_store[where]);
                if (rev_strand) begin
                  obs_ch = opposite_base(obs_ch);
                  queue_report('{KIND_MISMATCH, 11'(read_len - where), ref_ch, obs_ch});
                end else begin
                  queue_report('{KIND_MISMATCH, 11'(where + 1), ref_ch, obs_ch});
                end
                cursor_pos = where + 1;
              end
            end
          end
          default: ;
        endcase
      end
    end
    mismatch_count <= err_total;
    outstanding    <= expected_reports.size();
  end

endmodule

// File: bench/tb_md_tag_mismatch_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md_tag_mismatch_extractor
// Drives reads and MD tags into the mismatch extractor: a load of the low
// read store entries and the last one, a directed set of corner cases, then
// random well-formed MD tags mixed with noise, under random idling on both
// sides and one long output hold-off. Checking is done by
// md_tag_mismatch_checker.
// ----------------------------------------------------------------------------
module tb_md_tag_mismatch_extractor;
  import mte_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         STORE_SIZE = 1024;
  localparam int         PRELOAD = 256;
  localparam int         RANDOM_REQS = 300;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_START;
  logic [10:0] in_read_length = '0;
  logic        in_is_reverse = 1'b0;
  logic [9:0]  in_base_index = '0;
  logic [3:0]  in_base_code = '0;
  logic [7:0]  in_md_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [10:0] out_position;
  logic [7:0]  out_reference_base;
  logic [7:0]  out_observed_base;

  int mismatch_count;
  int outstanding;
  int sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit quiet = 1'b0;
  bit squeeze = 1'b0;

  md_tag_mismatch_extractor #(.MAX_READ_LEN(STORE_SIZE)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_read_length     (in_read_length),
    .in_is_reverse      (in_is_reverse),
    .in_base_index      (in_base_index),
    .in_base_code       (in_base_code),
    .in_md_char         (in_md_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_position       (out_position),
    .out_reference_base (out_reference_base),
    .out_observed_base  (out_observed_base)
  );

  md_tag_mismatch_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_read_length     (in_read_length),
    .in_is_reverse      (in_is_reverse),
    .in_base_index      (in_base_index),
    .in_base_code       (in_base_code),
    .in_md_char         (in_md_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_position       (out_position),
    .out_reference_base (out_reference_base),
    .out_observed_base  (out_observed_base),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Offer one request and hold it until it is taken.
  task automatic send_req(input logic [1:0] cmd, input logic [10:0] len, input logic rev,
                          input logic [9:0] idx, input logic [3:0] code,
                          input logic [7:0] ch);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_read_length <= len;
    in_is_reverse  <= rev;
    in_base_index  <= idx;
    in_base_code   <= code;
    in_md_char     <= ch;
    do @(posedge clk); while (in_stall);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  // Unused fields carry random values so that they are seen to be ignored.
  task automatic start_read(input int len, input bit rev);
    send_req(CMD_START, 11'(len), rev, 10'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic put_base(input int idx, input int code);
    send_req(CMD_BASE, 11'($urandom), 1'($urandom), 10'(idx), 4'(code), 8'($urandom));
  endtask

  task automatic md(input logic [7:0] ch);
    send_req(CMD_MD_CHAR, 11'($urandom), 1'($urandom), 10'($urandom), 4'($urandom), ch);
  endtask

  task automatic md_run(input int run);
    int digits[$];
    if (run == 0) digits.push_front(0);
    while (run > 0) begin
      digits.push_front(run % 10);
      run = run / 10;
    end
    foreach (digits[i]) md(CH_ZERO + 8'(digits[i]));
  endtask

  function automatic bit is_alnum(input logic [7:0] ch);
    return (ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_UA && ch <= CH_UZ) ||
           (ch >= CH_LA && ch <= CH_LZ);
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0, 1:    ch = CH_A;
      2, 3:    ch = CH_C;
      4:       ch = CH_G;
      5, 6:    ch = CH_T;
      7:       ch = CH_N;
      default: ch = 8'($urandom_range(CH_UA, CH_UZ));
    endcase
    if ($urandom_range(0, 3) == 0) ch = ch + CASE_OFFSET;
    return ch;
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] ch;
    do ch = 8'($urandom); while (is_alnum(ch));
    return ch;
  endfunction

  // Any character but a letter: noise never reads a base.
  function automatic logic [7:0] pick_noise_char();
    logic [7:0] ch;
    do ch = 8'($urandom);
    while ((ch >= CH_UA && ch <= CH_UZ) || (ch >= CH_LA && ch <= CH_LZ));
    return ch;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Output side: short random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
        squeeze = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int  first_random;
    int  len;
    int  eff;
    int  run;
    bit  squeezed;
    squeezed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Load the low entries and the last one; letters below only reach those.
    gap_pct   = 10;
    stall_pct = 10;
    for (int i = 0; i < PRELOAD; i++) put_base(i, $urandom_range(0, 15));
    put_base(STORE_SIZE - 1, $urandom_range(0, 15));

    // Forward read: empty and N codes, lowest-bit decode, beyond-read letter.
    start_read(10, 1'b0);
    put_base(0, CODE_NONE);
    put_base(1, CODE_N);
    put_base(2, 4'h8);
    put_base(3, 4'h6);
    put_base(9, 4'h4);
    md(CH_A);
    md(CH_C + CASE_OFFSET);
    md(CH_G);
    md(CH_ZERO);
    md(CH_T);
    md(CH_ZERO + 8'd5);
    md(CH_G + CASE_OFFSET);
    md(CH_A);
    // Characters outside the tag alphabet, and an unused command.
    md(8'h5E);
    md(8'hFF);
    md(8'h00);
    send_req(CMD_UNUSED, 11'h7FF, 1'b1, 10'h3FF, 4'hF, CH_A);
    // Oversized read on the reverse strand; the run saturates.
    start_read(2047, 1'b1);
    repeat (4) md(CH_NINE);
    md(CH_C);
    // Last base of a full read, mirrored to position 1, then past the end.
    start_read(1024, 1'b1);
    md_run(1023);
    md(CH_T + CASE_OFFSET);
    md(CH_A);
    // Empty read, and a reverse-strand N.
    start_read(0, 1'b0);
    md(CH_N);
    start_read(5, 1'b1);
    md(CH_N + CASE_OFFSET);

    first_random = sent;
    while (sent - first_random < RANDOM_REQS) begin
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      if (sent - first_random >= RANDOM_REQS - 80) quiet = 1'b1;

      if (!squeezed && sent - first_random >= 120) begin
        // Hold the output while letters keep coming so the block backs up.
        squeezed = 1'b1;
        squeeze  = 1'b1;
        start_read(1024, 1'($urandom));
        repeat (40) begin
          if ($urandom_range(0, 1)) md_run($urandom_range(0, 4));
          md(pick_letter());
        end
      end else if ($urandom_range(0, 6) != 0) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(49, 2047) : $urandom_range(1, 48);
        eff = (len > STORE_SIZE) ? STORE_SIZE : len;
        start_read(len, 1'($urandom));
        if (eff <= 48 && $urandom_range(0, 1))
          for (int i = 0; i < eff; i++) put_base(i, $urandom_range(0, 15));
        repeat ($urandom_range(0, 2)) put_base($urandom_range(0, STORE_SIZE - 1),
                                               $urandom_range(0, 15));
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 11) == 0) run = $urandom_range(eff, 3000);
          else run = $urandom_range(0, ((eff > 48) ? 48 : eff) / 3 + 2);
          if (run != 0 || $urandom_range(0, 1)) md_run(run);
          if ($urandom_range(0, 9) == 0) md(pick_junk());
          md(pick_letter());
        end
        if ($urandom_range(0, 1)) md_run($urandom_range(0, eff));
      end else begin
        // Noise: any command with any field values, letters left out.
        repeat ($urandom_range(3, 12)) begin
          send_req(2'($urandom), 11'($urandom), 1'($urandom), 10'($urandom),
                   4'($urandom), pick_noise_char());
        end
      end
    end
    in_valid <= 1'b0;

    for (int k = 0; k < 4000 && outstanding != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mte_pkg.sv
hdl/mte_ram.sv
hdl/mte_parse.sv
hdl/mte_emit.sv
hdl/md_tag_mismatch_extractor.sv
bench/md_tag_mismatch_checker.sv
bench/tb_md_tag_mismatch_extractor.sv
